FILE: sv/pa_pkg.sv
// Shared types and constants of the primitive assembler.
package pa_pkg;

    localparam int PORT_W          = 16;   // index width on the ports
    localparam int INDEX_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [3:0] MODE_POINTS     = 4'd0;
    localparam logic [3:0] MODE_LINES      = 4'd1;
    localparam logic [3:0] MODE_LINE_LOOP  = 4'd2;
    localparam logic [3:0] MODE_LINE_STRIP = 4'd3;
    localparam logic [3:0] MODE_TRIS       = 4'd4;
    localparam logic [3:0] MODE_TRI_STRIP  = 4'd5;
    localparam logic [3:0] MODE_TRI_FAN    = 4'd6;
    localparam logic [3:0] MODE_QUADS      = 4'd7;
    localparam logic [3:0] MODE_QUAD_STRIP = 4'd8;
    localparam logic [3:0] MODE_POLYGON    = 4'd9;

    typedef enum logic [1:0] {
        KIND_POINT = 2'd0,
        KIND_LINE  = 2'd1,
        KIND_TRI   = 2'd2
    } kind_t;

    typedef struct packed {
        logic [PORT_W-1:0] idx;
        logic              flag;
    } vtx_t;

    // One assembled job; a quad job expands into two triangles.
    typedef struct packed {
        kind_t kind;
        logic  quad;
        vtx_t  p0;
        vtx_t  p1;
        vtx_t  p2;
        vtx_t  p3;
    } job_t;

endpackage

FILE: sv/primitive_assembler.sv
// Top level of the primitive assembler: front end, job queue and back end.
//
// Usage: vertices arrive as beats on the s_ channel (index, edge flag, batch
// end); assembled points, lines and triangles leave as beats on the m_ channel.
// Both channels use valid/ready; a beat moves when valid and ready are high.
// cfg_we/cfg_wdata write the primitive mode; write it only while idle. A mode
// write restarts primitive assembly.
// A completing vertex puts its job into the queue at the accepting edge;
// the job moves into the output register once that register is free. Both
// triangles of a quad come from one queue entry, popped with the second.
// Throughput: one vertex per cycle while the queue is not full, one result
// beat per cycle while m_ready is high; quads and quad strips produce two
// beats per completing vertex, so the output register sets the rate.
// The four-entry job queue decouples the sides: while the receiver stalls,
// vertices are still taken until the queue fills, then s_ready drops.
// Reset: mode returns to points, held vertices and counters clear, queue and
// output register empty; the block is ready as soon as reset is released.
module primitive_assembler #(
    parameter int INDEX_WIDTH = pa_pkg::INDEX_WIDTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [3:0]                cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [pa_pkg::PORT_W-1:0] s_vertex_index,
    input  logic                      s_edge_flag,
    input  logic                      s_batch_end,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_prim_kind,
    output logic [pa_pkg::PORT_W-1:0] m_vertex_a,
    output logic [pa_pkg::PORT_W-1:0] m_vertex_b,
    output logic [pa_pkg::PORT_W-1:0] m_vertex_c,
    output logic                      m_edge_a,
    output logic                      m_edge_b,
    output logic                      m_edge_c,
    output logic                      m_last_of_run
);

    logic         q_full, q_push, q_empty, q_pop;
    pa_pkg::job_t push_job, head_job;

    pa_front #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_vertex_index (s_vertex_index),
        .s_edge_flag    (s_edge_flag),
        .s_batch_end    (s_batch_end),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_job          (push_job)
    );

    pa_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_job (head_job)
    );

    pa_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_head        (head_job),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_prim_kind   (m_prim_kind),
        .m_vertex_a    (m_vertex_a),
        .m_vertex_b    (m_vertex_b),
        .m_vertex_c    (m_vertex_c),
        .m_edge_a      (m_edge_a),
        .m_edge_b      (m_edge_b),
        .m_edge_c      (m_edge_c),
        .m_last_of_run (m_last_of_run)
    );

endmodule

FILE: sv/pa_front.sv
// Front end: accepts vertices, keeps the held vertices and builds primitive jobs.
module pa_front #(
    parameter int INDEX_WIDTH = pa_pkg::INDEX_WIDTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [3:0]                cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [pa_pkg::PORT_W-1:0] s_vertex_index,
    input  logic                      s_edge_flag,
    input  logic                      s_batch_end,
    input  logic                      q_full,
    output logic                      q_push,
    output pa_pkg::job_t              q_job
);

    localparam int HW = (INDEX_WIDTH < pa_pkg::PORT_W) ? INDEX_WIDTH : pa_pkg::PORT_W;

    logic [3:0]    mode_reg;
    logic [HW-1:0] held_idx_reg  [3];
    logic          held_flag_reg [3];
    logic [2:0]    cnt_reg, cnt_next;
    logic          parity_reg, parity_next;

    logic          accept;
    logic          emit;
    logic          wr_en;
    logic [1:0]    wr_sel;
    logic          shift_strip;   // held0 <= held1, held1 <= v
    logic          shift_qstrip;  // held0 <= held2, held1 <= v
    logic          set_h1;        // held1 <= v
    pa_pkg::vtx_t  v, h0, h1, h2, none;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    assign v.idx  = pa_pkg::PORT_W'(s_vertex_index[HW-1:0]);
    assign v.flag = s_edge_flag;
    assign h0.idx  = pa_pkg::PORT_W'(held_idx_reg[0]);
    assign h0.flag = held_flag_reg[0];
    assign h1.idx  = pa_pkg::PORT_W'(held_idx_reg[1]);
    assign h1.flag = held_flag_reg[1];
    assign h2.idx  = pa_pkg::PORT_W'(held_idx_reg[2]);
    assign h2.flag = held_flag_reg[2];
    assign none    = '0;

    always_comb begin
        emit         = 1'b0;
        wr_en        = 1'b0;
        wr_sel       = cnt_reg[1:0];
        shift_strip  = 1'b0;
        shift_qstrip = 1'b0;
        set_h1       = 1'b0;
        cnt_next     = cnt_reg;
        parity_next  = parity_reg;
        q_job        = '0;
        q_job.kind   = pa_pkg::KIND_TRI;
        case (mode_reg)
            pa_pkg::MODE_POINTS: begin
                emit       = 1'b1;
                q_job.kind = pa_pkg::KIND_POINT;
                q_job.p0   = v;
                q_job.p1   = none;
                q_job.p2   = none;
            end
            pa_pkg::MODE_LINES: begin
                q_job.kind = pa_pkg::KIND_LINE;
                q_job.p0   = h0;
                q_job.p1   = v;
                if (cnt_reg >= 3'd1) begin
                    emit     = 1'b1;
                    cnt_next = 3'd0;
                end else begin
                    wr_en    = 1'b1;
                    wr_sel   = 2'd0;
                    cnt_next = 3'd1;
                end
            end
            pa_pkg::MODE_LINE_LOOP, pa_pkg::MODE_LINE_STRIP: begin
                q_job.kind = pa_pkg::KIND_LINE;
                q_job.p0   = h0;
                q_job.p1   = v;
                emit       = (cnt_reg >= 3'd1);
                wr_en      = 1'b1;
                wr_sel     = 2'd0;
                cnt_next   = 3'd1;
            end
            pa_pkg::MODE_TRIS: begin
                q_job.p0 = h0;
                q_job.p1 = h1;
                q_job.p2 = v;
                if (cnt_reg >= 3'd2) begin
                    emit     = 1'b1;
                    cnt_next = 3'd0;
                end else begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            pa_pkg::MODE_TRI_STRIP: begin
                q_job.p0 = parity_reg ? h1 : h0;
                q_job.p1 = parity_reg ? h0 : h1;
                q_job.p2 = v;
                if (cnt_reg >= 3'd2) begin
                    emit        = 1'b1;
                    shift_strip = 1'b1;
                    parity_next = !parity_reg;
                    cnt_next    = 3'd2;
                end else begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            pa_pkg::MODE_TRI_FAN, pa_pkg::MODE_POLYGON: begin
                if (mode_reg == pa_pkg::MODE_TRI_FAN) begin
                    q_job.p0 = h0;
                    q_job.p1 = h1;
                    q_job.p2 = v;
                end else begin
                    q_job.p0 = h1;
                    q_job.p1 = v;
                    q_job.p2 = h0;
                end
                if (cnt_reg >= 3'd2) begin
                    emit     = 1'b1;
                    set_h1   = 1'b1;
                    cnt_next = 3'd2;
                end else begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            pa_pkg::MODE_QUADS: begin
                q_job.quad = 1'b1;
                q_job.p0   = h0;
                q_job.p1   = h1;
                q_job.p2   = h2;
                q_job.p3   = v;
                if (cnt_reg >= 3'd3) begin
                    emit     = 1'b1;
                    cnt_next = 3'd0;
                end else begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            pa_pkg::MODE_QUAD_STRIP: begin
                q_job.quad = 1'b1;
                q_job.p0   = h2;
                q_job.p1   = h0;
                q_job.p2   = h1;
                q_job.p3   = v;
                if (cnt_reg >= 3'd3) begin
                    emit         = 1'b1;
                    shift_qstrip = 1'b1;
                    cnt_next     = 3'd2;
                end else begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            default: begin
                // modes without meaning take vertices and emit nothing
            end
        endcase
    end

    assign q_push = accept && emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= pa_pkg::MODE_POINTS;
            cnt_reg       <= 3'd0;
            parity_reg    <= 1'b0;
            held_idx_reg  <= '{default: '0};
            held_flag_reg <= '{default: 1'b0};
        end else if (cfg_we) begin
            mode_reg   <= cfg_wdata;
            cnt_reg    <= 3'd0;
            parity_reg <= 1'b0;
        end else if (accept) begin
            if (s_batch_end) begin
                // drop incomplete primitive and restart
                cnt_reg       <= 3'd0;
                parity_reg    <= 1'b0;
                held_idx_reg  <= '{default: '0};
                held_flag_reg <= '{default: 1'b0};
            end else begin
                cnt_reg    <= cnt_next;
                parity_reg <= parity_next;
                if (wr_en && wr_sel != 2'd3) begin
                    held_idx_reg[wr_sel]  <= s_vertex_index[HW-1:0];
                    held_flag_reg[wr_sel] <= s_edge_flag;
                end
                if (shift_strip) begin
                    held_idx_reg[0]  <= held_idx_reg[1];
                    held_flag_reg[0] <= held_flag_reg[1];
                end
                if (shift_qstrip) begin
                    held_idx_reg[0]  <= held_idx_reg[2];
                    held_flag_reg[0] <= held_flag_reg[2];
                end
                if (shift_strip || shift_qstrip || set_h1) begin
                    held_idx_reg[1]  <= s_vertex_index[HW-1:0];
                    held_flag_reg[1] <= s_edge_flag;
                end
            end
        end
    end

endmodule

FILE: sv/pa_queue.sv
// Short job queue between the front end and the back end.
module pa_queue (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  pa_pkg::job_t push_job,
    output logic         full,
    input  logic         pop,
    output logic         empty,
    output pa_pkg::job_t head_job
);

    localparam int DEPTH = pa_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    pa_pkg::job_t  mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

FILE: sv/pa_back.sv
// Back end: expands queued jobs into result beats and holds the output register.
module pa_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_empty,
    input  pa_pkg::job_t              q_head,
    output logic                      q_pop,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_prim_kind,
    output logic [pa_pkg::PORT_W-1:0] m_vertex_a,
    output logic [pa_pkg::PORT_W-1:0] m_vertex_b,
    output logic [pa_pkg::PORT_W-1:0] m_vertex_c,
    output logic                      m_edge_a,
    output logic                      m_edge_b,
    output logic                      m_edge_c,
    output logic                      m_last_of_run
);

    logic          valid_reg;
    logic          phase_reg, phase_next;   // second triangle of a quad pending
    logic          advance;
    logic          load;
    pa_pkg::kind_t kind_reg;
    pa_pkg::vtx_t  a_reg, b_reg, c_reg;
    pa_pkg::vtx_t  a_next, b_next, c_next;
    logic          last_reg, last_next;

    assign advance = !valid_reg || m_ready;
    assign load    = advance && !q_empty;

    always_comb begin
        a_next     = q_head.p0;
        b_next     = q_head.p1;
        c_next     = q_head.p2;
        last_next  = 1'b1;
        phase_next = 1'b0;
        q_pop      = load;
        if (q_head.quad) begin
            if (!phase_reg) begin
                // first half: diagonal end p1 loses its edge flag; hold the job
                b_next.flag = 1'b0;
                c_next      = q_head.p3;
                last_next   = 1'b0;
                phase_next  = 1'b1;
                q_pop       = 1'b0;
            end else begin
                a_next      = q_head.p1;
                b_next      = q_head.p2;
                c_next      = q_head.p3;
                c_next.flag = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= !q_empty;
            if (load) begin
                phase_reg <= phase_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg <= q_head.kind;
            a_reg    <= a_next;
            b_reg    <= b_next;
            c_reg    <= c_next;
            last_reg <= last_next;
        end
    end

    assign m_valid       = valid_reg;
    assign m_prim_kind   = kind_reg;
    assign m_vertex_a    = a_reg.idx;
    assign m_vertex_b    = b_reg.idx;
    assign m_vertex_c    = c_reg.idx;
    assign m_edge_a      = a_reg.flag;
    assign m_edge_b      = b_reg.flag;
    assign m_edge_c      = c_reg.flag;
    assign m_last_of_run = last_reg;

endmodule
